// File: hw/rtl/qmix_pkg.sv
// qmix_pkg: item types, register indexes and reset values for the quadrotor motor mixer
// no dependencies; used by the channel interfaces and the top level

package qmix_pkg;

  // one wrench command
  typedef struct packed {
    logic signed [23:0] thrust_force;
    logic signed [23:0] roll_torque;
    logic signed [23:0] pitch_torque;
    logic signed [23:0] yaw_torque;
  } cmd_t;

  // four duties and the saturation flags
  typedef struct packed {
    logic [15:0] duty_motor_one;
    logic [15:0] duty_motor_two;
    logic [15:0] duty_motor_three;
    logic [15:0] duty_motor_four;
    logic [3:0]  saturation_mask;
  } duty_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRUST_GAIN   = 3'd0,
    REG_ARM_GAIN      = 3'd1,
    REG_DRAG_GAIN     = 3'd2,
    REG_DUTY_SQ_COEFF = 3'd3,
    REG_DUTY_LIN_COEFF = 3'd4
  } cfg_reg_e;

  localparam logic [23:0] ThrustGainRst  = 24'd630154;
  localparam logic [23:0] ArmGainRst     = 24'd18004;
  localparam logic [23:0] DragGainRst    = 24'd152950;
  localparam logic [19:0] DutySqCoeffRst = 20'd76671;
  localparam logic [15:0] DutyLinCoeffRst = 16'd3316;

endpackage

// File: hw/rtl/qmix_cmd_if.sv
// qmix_cmd_if: valid/ready channel that carries one wrench command item
// depends on qmix_pkg for the payload type

interface qmix_cmd_if;
  logic            valid;
  logic            ready;
  qmix_pkg::cmd_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/qmix_duty_if.sv
// qmix_duty_if: valid/ready channel that carries one motor duty item
// depends on qmix_pkg for the payload type

interface qmix_duty_if;
  logic             valid;
  logic             ready;
  qmix_pkg::duty_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/quadrotor_motor_mixer.sv
// quadrotor_motor_mixer: x-quad mixer from wrench command to four q16 motor duties
// depends on qmix_pkg, qmix_cmd_if and qmix_duty_if

// The mixer takes one wrench item per clock while cmd_i.ready is high and returns one
// duty item per item, in order. The nine register stages are: gain multiplies, the x
// sign-pattern sums with clamp and saturation, four square-root stages resolving four
// root bits each, speed squared and linear term, quadratic coefficient multiply, and the
// final sum with duty saturation in the output register. Each stage holds its item until
// the next stage can take it, so bubbles close up and cmd_i.ready stays high while any
// stage is free. Gains and motor coefficients are written through the ports
// cfg_we_i/cfg_idx_i/cfg_wdata_i and are read live by the stages, so they are to be changed
// only while no item is in flight; writes to unknown indexes are dropped.

module quadrotor_motor_mixer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [qmix_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [qmix_pkg::CfgDataW-1:0]      cfg_wdata_i,
  qmix_cmd_if.sink                           cmd_i,
  qmix_duty_if.source                        duty_o
);

  localparam int unsigned NumStg   = 9;   // pipeline depth
  localparam int unsigned NumMot   = 4;
  localparam int unsigned SqStg    = 4;   // square-root stages
  localparam int unsigned SqBits   = 4;   // root bits per square-root stage
  localparam int unsigned StgSqEnd = 5;   // stage holding the finished root
  localparam int unsigned StgWw    = 6;
  localparam int unsigned StgA2    = 7;
  localparam int unsigned StgOut   = 8;

  typedef struct packed {
    logic [31:0] rem;
    logic [15:0] root;
  } sq_step_t;

  // one digit-by-digit square root step for root bit b
  function automatic sq_step_t sqrt_step(input logic [31:0] rem, input logic [15:0] root,
                                         input int unsigned b);
    logic [33:0] trial;
    sq_step_t    r;
    trial  = ({18'd0, root} << (b + 1)) + (34'd1 << (2 * b));
    r.rem  = rem;
    r.root = root;
    if ({2'b00, rem} >= trial) begin
      r.rem  = rem - trial[31:0];
      r.root = root | (16'd1 << b);
    end
    return r;
  endfunction

  // configuration registers
  logic [23:0] thrust_gain_q, arm_gain_q, drag_gain_q;
  logic [19:0] duty_sq_coeff_q;
  logic [15:0] duty_lin_coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thrust_gain_q    <= qmix_pkg::ThrustGainRst;
      arm_gain_q       <= qmix_pkg::ArmGainRst;
      drag_gain_q      <= qmix_pkg::DragGainRst;
      duty_sq_coeff_q  <= qmix_pkg::DutySqCoeffRst;
      duty_lin_coeff_q <= qmix_pkg::DutyLinCoeffRst;
    end else if (cfg_we_i) begin
      unique case (qmix_pkg::cfg_reg_e'(cfg_idx_i))
        qmix_pkg::REG_THRUST_GAIN:    thrust_gain_q    <= cfg_wdata_i;
        qmix_pkg::REG_ARM_GAIN:       arm_gain_q       <= cfg_wdata_i;
        qmix_pkg::REG_DRAG_GAIN:      drag_gain_q      <= cfg_wdata_i;
        qmix_pkg::REG_DUTY_SQ_COEFF:  duty_sq_coeff_q  <= cfg_wdata_i[19:0];
        qmix_pkg::REG_DUTY_LIN_COEFF: duty_lin_coeff_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance: a stage loads when it is empty or drains
  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] en;

  always_comb begin
    en[NumStg-1] = !v_q[NumStg-1] || duty_o.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign cmd_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= cmd_i.valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: gain products (all exact)
  logic signed [24:0] sum_in, dif_in;
  logic signed [48:0] f_d, yaw_d, f_q, yaw_q;
  logic signed [49:0] sxy_d, dxy_d, sxy_q, dxy_q;

  assign sum_in = {cmd_i.payload.roll_torque[23], cmd_i.payload.roll_torque}
                + {cmd_i.payload.pitch_torque[23], cmd_i.payload.pitch_torque};
  assign dif_in = {cmd_i.payload.roll_torque[23], cmd_i.payload.roll_torque}
                - {cmd_i.payload.pitch_torque[23], cmd_i.payload.pitch_torque};
  assign f_d   = $signed({1'b0, thrust_gain_q}) * cmd_i.payload.thrust_force;
  assign sxy_d = $signed({1'b0, arm_gain_q}) * sum_in;
  assign dxy_d = $signed({1'b0, arm_gain_q}) * dif_in;
  assign yaw_d = $signed({1'b0, drag_gain_q}) * cmd_i.payload.yaw_torque;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      f_q   <= f_d;
      sxy_q <= sxy_d;
      dxy_q <= dxy_d;
      yaw_q <= yaw_d;
    end
  end

  // stage 1: x sign pattern, drop the q16 fraction, clamp at zero and 2^32-1
  logic signed [50:0] mix [NumMot];
  logic [31:0]        sq_d [NumMot];
  logic [NumMot-1:0]  sq_sat_d;

  always_comb begin
    mix[0] = 51'(f_q) - 51'(sxy_q) - 51'(yaw_q);
    mix[1] = 51'(f_q) - 51'(dxy_q) + 51'(yaw_q);
    mix[2] = 51'(f_q) + 51'(sxy_q) - 51'(yaw_q);
    mix[3] = 51'(f_q) + 51'(dxy_q) + 51'(yaw_q);
    for (int m = 0; m < NumMot; m++) begin
      priority if (mix[m][50]) begin
        sq_d[m]     = '0;
        sq_sat_d[m] = 1'b0;
      end else if (|mix[m][49:48]) begin
        sq_d[m]     = '1;
        sq_sat_d[m] = 1'b1;
      end else begin
        sq_d[m]     = mix[m][47:16];
        sq_sat_d[m] = 1'b0;
      end
    end
  end

  // remainder/root pairs: index 0 is stage 1, index g+1 is square-root stage g
  logic [31:0]       rem_q  [SqStg+1][NumMot];
  logic [15:0]       root_q [SqStg+1][NumMot];
  logic [NumMot-1:0] sat_q  [NumStg-2];   // entry k-1 travels with stage k

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int m = 0; m < NumMot; m++) begin
        rem_q[0][m]  <= sq_d[m];
        root_q[0][m] <= '0;
      end
      sat_q[0] <= sq_sat_d;
    end
  end

  // stages 2..5: four root bits per stage, most significant first
  for (genvar g = 0; g < SqStg; g++) begin : g_sqrt
    sq_step_t st [NumMot][SqBits+1];

    always_comb begin
      for (int m = 0; m < NumMot; m++) begin
        st[m][0].rem  = rem_q[g][m];
        st[m][0].root = root_q[g][m];
        for (int j = 0; j < SqBits; j++) begin
          st[m][j+1] = sqrt_step(st[m][j].rem, st[m][j].root,
                                 16 - SqBits * g - j - 1);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g+2]) begin
        for (int m = 0; m < NumMot; m++) begin
          rem_q[g+1][m]  <= st[m][SqBits].rem;
          root_q[g+1][m] <= st[m][SqBits].root;
        end
        sat_q[g+1] <= sat_q[g];
      end
    end
  end

  // stage 6: speed squared and linear term
  logic [31:0] ww_q [NumMot];
  logic [31:0] lw_q [NumMot];

  always_ff @(posedge clk_i) begin
    if (en[StgWw]) begin
      for (int m = 0; m < NumMot; m++) begin
        ww_q[m] <= root_q[SqStg][m] * root_q[SqStg][m];
        lw_q[m] <= duty_lin_coeff_q * root_q[SqStg][m];
      end
      sat_q[StgWw-1] <= sat_q[StgWw-2];
    end
  end

  // stage 7: quadratic coefficient times speed squared
  logic [51:0] a2ww_q [NumMot];
  logic [31:0] lw2_q  [NumMot];

  always_ff @(posedge clk_i) begin
    if (en[StgA2]) begin
      for (int m = 0; m < NumMot; m++) begin
        a2ww_q[m] <= duty_sq_coeff_q * ww_q[m];
        lw2_q[m]  <= lw_q[m];
      end
      sat_q[StgA2-1] <= sat_q[StgA2-2];
    end
  end

  // stage 8: sum, scale by 2^-24, saturate duty
  logic [52:0]       dsum   [NumMot];
  logic [15:0]       duty_v [NumMot];
  logic [NumMot-1:0] dsat;
  qmix_pkg::duty_t   out_d, out_q;

  always_comb begin
    for (int m = 0; m < NumMot; m++) begin
      dsum[m] = 53'(a2ww_q[m]) + {5'd0, lw2_q[m], 16'd0};
      dsat[m] = |dsum[m][52:40];
      duty_v[m] = dsat[m] ? 16'hFFFF : dsum[m][39:24];
    end
    out_d.duty_motor_one   = duty_v[0];
    out_d.duty_motor_two   = duty_v[1];
    out_d.duty_motor_three = duty_v[2];
    out_d.duty_motor_four  = duty_v[3];
    out_d.saturation_mask  = dsat | sat_q[StgA2-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[StgOut]) begin
      out_q <= out_d;
    end
  end

  assign duty_o.valid   = v_q[StgOut];
  assign duty_o.payload = out_q;

  // a command is taken only when some stage has room
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ready |-> (!(&v_q) || duty_o.ready))
    else $error("command taken with a full, stalled pipeline");

  // a delivered item with nothing behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_o.valid && duty_o.ready && !v_q[StgA2]) |=> !duty_o.valid)
    else $error("output item repeated");

  for (genvar m = 0; m < NumMot; m++) begin : g_chk
    // a saturated squared speed enters the root as all ones
    a_sq_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v_q[1] && sat_q[0][m]) |-> (rem_q[0][m] == 32'hFFFFFFFF))
      else $error("squared speed saturation flag without clamp");

    // finished root leaves a remainder of at most twice the root
    a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q[StgSqEnd] |-> ({1'b0, rem_q[SqStg][m]} <= {16'd0, root_q[SqStg][m], 1'b0}))
      else $error("square root remainder out of range");
  end

endmodule
